// File: rtl/core/fractal_iteration_colour_map_unit_assert.svh
// assertion macros for the fractal iteration colour map unit
`ifndef FRACTAL_ITERATION_COLOUR_MAP_UNIT_ASSERT_SVH
`define FRACTAL_ITERATION_COLOUR_MAP_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FICM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FICM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ficm_pkg.sv
// shared constants, palette and register codes for the colour map unit
package ficm_pkg;

    // field widths
    localparam int ITER_BITS  = 16;
    localparam int FRAC_BITS  = 8;
    localparam int ZOOM_W     = 16 + FRAC_BITS;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIXEL_W    = 32;
    localparam int CFG_DATA_W = 32;

    // fixed point one and the fold window (1, 7]
    localparam int ONE_Z      = 1 << FRAC_BITS;
    localparam int ZOOM_TOP   = 7 * ONE_Z;

    // blend fraction runs from 0 to one inclusive
    localparam int T_W        = FRAC_BITS + 1;
    localparam int MIX_W      = CH_W + T_W;

    // palette segment select
    localparam int SEG_W      = 3;
    localparam int SEG_MAX    = 5;
    localparam int RING_LEN   = 7;

    // fold count: excess / (6 * one) = (excess >> (FRAC_BITS + 1)) / 3
    localparam int Q_W        = ZOOM_W - FRAC_BITS - 1;
    localparam int RECIP_S    = Q_W + 1;
    localparam int RECIP      = ((2 ** RECIP_S) + 2) / 3;
    localparam int PROD_W     = Q_W + RECIP_S;

    // scale divider: quotient fits in one channel
    localparam int NUM_W          = CH_W + ITER_BITS;
    localparam int DIV_BITS_STAGE = 2;
    localparam int NUM_DIV_STAGES = CH_W / DIV_BITS_STAGE;
    localparam int NUM_STAGES     = 4 + NUM_DIV_STAGES;

    // reset values
    localparam logic [ITER_BITS-1:0] MAX_ITER_RESET = ITER_BITS'(100);
    localparam logic [ZOOM_W-1:0]    ZOOM_RESET     = ZOOM_W'(ONE_Z);

    // output constants
    localparam logic [PIXEL_W-1:0] BLACK_PIXEL = 32'h0000_00FF;
    localparam logic [CH_W-1:0]    ALPHA       = 8'hFF;

    // rainbow ring, first colour repeated at the end
    localparam logic [23:0] RING [RING_LEN] = '{
        24'hE40303, 24'hFF8C00, 24'hFFED00, 24'h008026,
        24'h24408E, 24'h732982, 24'hE40303
    };

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MAX_ITER = 1'b0,
        CFG_ZOOM     = 1'b1
    } cfg_reg_t;

endpackage

// File: rtl/core/fractal_iteration_colour_map_unit.sv
// Fractal iteration colour map: takes one iteration count per cycle and returns one
// RGBA pixel per item, in order, after eight pipeline stages (fold count by reciprocal
// multiply, segment and fraction, palette blend, scale product, then a four-stage
// divider that resolves two quotient bits per stage). Throughput is one item per cycle
// when the result side keeps up; a stall on the result side holds the last stage and
// every full stage directly behind it, while stages behind an empty one keep moving up,
// and input is refused only when all eight stages hold items and the result side stalls.
// The two registers are written through the cfg port, which is always ready, and are
// read by the stages directly, so they must only change while no item is in flight.
module fractal_iteration_colour_map_unit
    import ficm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // iteration count items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ITER_BITS-1:0]  s_iteration_count,
    // pixel items
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIXEL_W-1:0]    m_pixel_colour
);

    // configuration registers
    logic [ITER_BITS-1:0] max_iter_reg;
    logic [ZOOM_W-1:0]    zoom_reg;

    // pipeline control
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] black_reg;
    logic [NUM_STAGES-1:0] en;

    // stage 0: fold count
    logic [ITER_BITS-1:0] it0_reg;
    logic                 over0_reg;
    logic [Q_W-1:0]       q0_reg;
    logic                 black0_next;
    logic                 over0_next;
    logic [Q_W-1:0]       q0_next;
    logic [ZOOM_W-1:0]    zoom_excess;
    logic [PROD_W-1:0]    fold_prod;

    // stage 1: segment and fraction
    logic [ITER_BITS-1:0] it1_reg;
    logic [SEG_W-1:0]     seg_reg;
    logic [T_W-1:0]       t_reg;
    logic [SEG_W-1:0]     seg_next;
    logic [T_W-1:0]       t_next;
    logic [Q_W:0]         q_inc;
    logic [Q_W+2:0]       q_times3;
    logic [ZOOM_W-1:0]    fold_sub;
    logic [ZOOM_W-1:0]    zoom_fold;
    logic [ZOOM_W-1:0]    zoom_off;
    logic [ZOOM_W-FRAC_BITS-1:0] seg_wide;

    // stage 2: blended colour
    logic [ITER_BITS-1:0] it2_reg;
    logic [CH_W-1:0]      col_reg  [NUM_CH];
    logic [CH_W-1:0]      col_next [NUM_CH];
    logic [SEG_W-1:0]     seg_hi;
    logic [T_W-1:0]       t_inv;

    // stage 3: scale product
    logic [NUM_W-1:0]     num_reg  [NUM_CH];
    logic [NUM_W-1:0]     num_next [NUM_CH];

    // stages 4 and up: divider
    logic [NUM_W-1:0] div_rem_reg  [NUM_DIV_STAGES][NUM_CH];
    logic [CH_W-1:0]  div_quo_reg  [NUM_DIV_STAGES][NUM_CH];
    logic [NUM_W-1:0] div_rem_next [NUM_DIV_STAGES][NUM_CH];
    logic [CH_W-1:0]  div_quo_next [NUM_DIV_STAGES][NUM_CH];

    // one restoring step: subtract the shifted divisor when it fits
    function automatic logic [NUM_W:0] div_step(
        input logic [NUM_W-1:0]     rem,
        input logic [ITER_BITS-1:0] d,
        input int unsigned          sh
    );
        logic [NUM_W-1:0] ds;
        ds = NUM_W'(d) << sh;
        if (rem >= ds) begin
            return {1'b1, NUM_W'(rem - ds)};
        end
        return {1'b0, rem};
    endfunction

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= MAX_ITER_RESET;
            zoom_reg     <= ZOOM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_MAX_ITER: max_iter_reg <= cfg_data[ITER_BITS-1:0];
                CFG_ZOOM:     zoom_reg     <= cfg_data[ZOOM_W-1:0];
                default:      max_iter_reg <= max_iter_reg;
            endcase
        end
    end

    // stage enables: a stage moves when empty or when the next one moves
    always_comb begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 0 logic: limit check and fold count q = (excess >> (F+1)) / 3
    always_comb begin
        black0_next = s_iteration_count >= max_iter_reg;
        over0_next  = zoom_reg > ZOOM_W'(ZOOM_TOP);
        zoom_excess = zoom_reg - ZOOM_W'(ZOOM_TOP + 1);
        fold_prod   = PROD_W'(zoom_excess[ZOOM_W-1:FRAC_BITS+1]) * PROD_W'(RECIP);
        q0_next     = fold_prod[PROD_W-1:RECIP_S];
    end

    // stage 1 logic: fold into (1, 7], then segment and fraction
    always_comb begin
        q_inc     = (Q_W+1)'(q0_reg) + (Q_W+1)'(1);
        q_times3  = (Q_W+3)'(q_inc) + ((Q_W+3)'(q_inc) << 1);
        fold_sub  = ZOOM_W'({q_times3, {(FRAC_BITS+1){1'b0}}});
        zoom_fold = over0_reg ? (zoom_reg - fold_sub) : zoom_reg;
        zoom_off  = zoom_fold - ZOOM_W'(ONE_Z + 1);
        seg_wide  = zoom_off[ZOOM_W-1:FRAC_BITS];
        seg_next  = '0;
        t_next    = '0;
        if (zoom_fold > ZOOM_W'(ONE_Z)) begin
            if (seg_wide > (ZOOM_W-FRAC_BITS)'(SEG_MAX)) begin
                seg_next = SEG_W'(SEG_MAX);
            end else begin
                seg_next = seg_wide[SEG_W-1:0];
            end
            t_next = T_W'(zoom_fold - ZOOM_W'(ONE_Z)
                          - (ZOOM_W'(seg_next) << FRAC_BITS));
        end
    end

    // stage 2 logic: linear blend of two neighboring colors per channel
    always_comb begin
        seg_hi = seg_reg + SEG_W'(1);
        t_inv  = T_W'(ONE_Z) - t_reg;
        for (int c = 0; c < NUM_CH; c++) begin
            logic [MIX_W-1:0] mix;
            mix = MIX_W'(t_reg) * MIX_W'(RING[seg_hi][(2-c)*CH_W +: CH_W])
                + MIX_W'(t_inv) * MIX_W'(RING[seg_reg][(2-c)*CH_W +: CH_W]);
            col_next[c] = mix[FRAC_BITS +: CH_W];
        end
    end

    // stage 3 logic: channel times count
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            num_next[c] = NUM_W'(col_reg[c]) * NUM_W'(it2_reg);
        end
    end

    // divider logic: two quotient bits per stage, msb first
    always_comb begin
        for (int j = 0; j < NUM_DIV_STAGES; j++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                logic [NUM_W-1:0] rem_in;
                logic [CH_W-1:0]  quo_in;
                logic [NUM_W:0]   step_hi;
                logic [NUM_W:0]   step_lo;
                rem_in  = (j == 0) ? num_reg[c] : div_rem_reg[(j == 0) ? 0 : j-1][c];
                quo_in  = (j == 0) ? '0 : div_quo_reg[(j == 0) ? 0 : j-1][c];
                step_hi = div_step(rem_in, max_iter_reg,
                                   unsigned'(CH_W - 1 - DIV_BITS_STAGE * j));
                step_lo = div_step(step_hi[NUM_W-1:0], max_iter_reg,
                                   unsigned'(CH_W - 2 - DIV_BITS_STAGE * j));
                div_rem_next[j][c] = step_lo[NUM_W-1:0];
                div_quo_next[j][c] = quo_in
                    | (CH_W'(step_hi[NUM_W]) << (CH_W - 1 - DIV_BITS_STAGE * j))
                    | (CH_W'(step_lo[NUM_W]) << (CH_W - 2 - DIV_BITS_STAGE * j));
            end
        end
    end

    // pipeline data registers
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            it0_reg      <= s_iteration_count;
            over0_reg    <= over0_next;
            q0_reg       <= q0_next;
            black_reg[0] <= black0_next;
        end
        if (en[1]) begin
            it1_reg      <= it0_reg;
            seg_reg      <= seg_next;
            t_reg        <= t_next;
            black_reg[1] <= black_reg[0];
        end
        if (en[2]) begin
            it2_reg      <= it1_reg;
            col_reg      <= col_next;
            black_reg[2] <= black_reg[1];
        end
        if (en[3]) begin
            num_reg      <= num_next;
            black_reg[3] <= black_reg[2];
        end
        for (int j = 0; j < NUM_DIV_STAGES; j++) begin
            if (en[4+j]) begin
                div_rem_reg[j] <= div_rem_next[j];
                div_quo_reg[j] <= div_quo_next[j];
                black_reg[4+j] <= black_reg[3+j];
            end
        end
    end

    // result item
    assign m_valid        = v_reg[NUM_STAGES-1];
    assign m_pixel_colour = black_reg[NUM_STAGES-1] ? BLACK_PIXEL
                          : {div_quo_reg[NUM_DIV_STAGES-1][0],
                             div_quo_reg[NUM_DIV_STAGES-1][1],
                             div_quo_reg[NUM_DIV_STAGES-1][2], ALPHA};

    // checks
`include "fractal_iteration_colour_map_unit_assert.svh"

    `FICM_ASSERT_NOW(a_full_when_blocked, aclk, aresetn, !s_ready, &v_reg, "input refused with a free stage")
    `FICM_ASSERT_NEXT(a_black_captured, aclk, aresetn, s_valid && s_ready && (s_iteration_count >= max_iter_reg), v_reg[0] && black_reg[0], "limit item not flagged")
    `FICM_ASSERT_NOW(a_seg_range, aclk, aresetn, v_reg[1], (seg_reg <= SEG_W'(SEG_MAX)) && (t_reg <= T_W'(ONE_Z)), "segment or fraction out of range")
    `FICM_ASSERT_NOW(a_div_rem, aclk, aresetn, m_valid && !black_reg[NUM_STAGES-1], (div_rem_reg[NUM_DIV_STAGES-1][0] < NUM_W'(max_iter_reg)) && (div_rem_reg[NUM_DIV_STAGES-1][1] < NUM_W'(max_iter_reg)) && (div_rem_reg[NUM_DIV_STAGES-1][2] < NUM_W'(max_iter_reg)), "divider remainder not below limit")

endmodule
